// ----- design/glyph_rom_address_calc_macros.svh -----
// Assertion macros shared by the glyph address calculator modules.
`ifndef GLYPH_ROM_ADDRESS_CALC_MACROS_SVH
`define GLYPH_ROM_ADDRESS_CALC_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define GRA_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("glyph address calc: implication check failed");

// Next-cycle implication, checked outside reset.
`define GRA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("glyph address calc: next-cycle check failed");

`endif

// ----- design/gra_pkg.sv -----
// Types, constants and font tables of the glyph address calculator.
package gra_pkg;

    typedef enum logic [2:0] {
        FONT_HANZI    = 3'd0,
        FONT_ASCII7X8 = 3'd1,
        FONT_GB8X16   = 3'd2,
        FONT_ASCII8X16 = 3'd3,
        FONT_ASCII5X7 = 3'd4,
        FONT_ARIAL    = 3'd5,
        FONT_BOLD8X16 = 3'd6,
        FONT_TIMES    = 3'd7
    } t_font_kind;

    localparam int ADDR_W = 18;
    localparam int IDX_W  = 13;
    localparam int OFS_W  = 7;
    localparam int ADD_W  = 10;
    localparam int STR_W  = 6;
    localparam int SIZE_W = 5;

    // hanzi zones
    localparam logic [7:0] HZ_LO_MIN   = 8'hA1;
    localparam logic [7:0] HZ_ROW_A9   = 8'hA9;
    localparam logic [7:0] HZ_ROW1_LO  = 8'hA1;
    localparam logic [7:0] HZ_ROW1_HI  = 8'hA3;
    localparam logic [7:0] HZ_ROW2_LO  = 8'hB0;
    localparam logic [7:0] HZ_ROW2_HI  = 8'hF7;
    localparam logic [IDX_W-1:0] HZ_ROW_LEN  = IDX_W'(94);
    localparam logic [ADD_W-1:0] HZ_A9_OFS   = ADD_W'(282);
    localparam logic [ADD_W-1:0] HZ_ROW2_OFS = ADD_W'(846);
    // last row 0xF7 with low byte 0xFF
    localparam logic [IDX_W-1:0] HZ_IDX_MAX  = IDX_W'(7614);

    // 8x16 GB2312 ranges
    localparam logic [7:0] GB_ROW_A    = 8'hAA;
    localparam logic [7:0] GB_ROW_B    = 8'hAB;
    localparam logic [7:0] GB_LO_MAX_A = 8'hFE;
    localparam logic [7:0] GB_LO_MAX_B = 8'hC0;
    localparam logic [ADD_W-1:0] GB_B_OFS = ADD_W'(95);

    // printable ASCII
    localparam logic [15:0] ASC_MIN = 16'h0020;
    localparam logic [15:0] ASC_MAX = 16'h007E;
    localparam logic [OFS_W-1:0] ASC_MIN_OFS = OFS_W'(32);

    typedef struct packed {
        t_font_kind        kind;
        logic              ok;
        logic [OFS_W-1:0]  row_off;
        logic [OFS_W-1:0]  col_off;
        logic [ADD_W-1:0]  idx_add;
    } t_dec_word;

    typedef struct packed {
        t_font_kind        kind;
        logic              ok;
        logic [IDX_W-1:0]  idx;
    } t_idx_word;

    typedef struct packed {
        logic              ok;
        logic [ADDR_W-1:0] addr;
        logic [SIZE_W-1:0] cols;
        logic [SIZE_W-1:0] rows;
        logic [SIZE_W-1:0] words;
    } t_out_word;

    function automatic logic [ADDR_W-1:0] font_base(input t_font_kind kind);
        logic [ADDR_W-1:0] v;
        unique case (kind)
            FONT_HANZI:     v = 18'h00000;
            FONT_ASCII7X8:  v = 18'h066C0;
            FONT_GB8X16:    v = 18'h3B7D0;
            FONT_ASCII8X16: v = 18'h3B7C0;
            FONT_ASCII5X7:  v = 18'h3BFC0;
            FONT_ARIAL:     v = 18'h3C2C0;
            FONT_BOLD8X16:  v = 18'h3CF80;
            FONT_TIMES:     v = 18'h3D580;
            default:        v = '0;
        endcase
        return v;
    endfunction

    function automatic logic [STR_W-1:0] font_stride(input t_font_kind kind);
        logic [STR_W-1:0] v;
        unique case (kind)
            FONT_HANZI:     v = STR_W'(32);
            FONT_ASCII7X8:  v = STR_W'(8);
            FONT_GB8X16:    v = STR_W'(16);
            FONT_ASCII8X16: v = STR_W'(16);
            FONT_ASCII5X7:  v = STR_W'(8);
            FONT_ARIAL:     v = STR_W'(34);
            FONT_BOLD8X16:  v = STR_W'(16);
            FONT_TIMES:     v = STR_W'(34);
            default:        v = '0;
        endcase
        return v;
    endfunction

    function automatic logic [SIZE_W-1:0] font_cols(input t_font_kind kind);
        logic [SIZE_W-1:0] v;
        unique case (kind)
            FONT_HANZI:     v = SIZE_W'(16);
            FONT_ASCII7X8:  v = SIZE_W'(7);
            FONT_GB8X16:    v = SIZE_W'(8);
            FONT_ASCII8X16: v = SIZE_W'(8);
            FONT_ASCII5X7:  v = SIZE_W'(5);
            FONT_BOLD8X16:  v = SIZE_W'(8);
            default:        v = '0;
        endcase
        return v;
    endfunction

    function automatic logic [SIZE_W-1:0] font_rows(input t_font_kind kind);
        logic [SIZE_W-1:0] v;
        unique case (kind)
            FONT_HANZI:     v = SIZE_W'(16);
            FONT_ASCII7X8:  v = SIZE_W'(8);
            FONT_GB8X16:    v = SIZE_W'(16);
            FONT_ASCII8X16: v = SIZE_W'(16);
            FONT_ASCII5X7:  v = SIZE_W'(7);
            FONT_BOLD8X16:  v = SIZE_W'(16);
            default:        v = '0;
        endcase
        return v;
    endfunction

    // rows * cols / 16, truncated
    function automatic logic [SIZE_W-1:0] font_words(input t_font_kind kind);
        logic [SIZE_W-1:0] v;
        unique case (kind)
            FONT_HANZI:     v = SIZE_W'(16);
            FONT_ASCII7X8:  v = SIZE_W'(3);
            FONT_GB8X16:    v = SIZE_W'(8);
            FONT_ASCII8X16: v = SIZE_W'(8);
            FONT_ASCII5X7:  v = SIZE_W'(2);
            FONT_BOLD8X16:  v = SIZE_W'(8);
            default:        v = '0;
        endcase
        return v;
    endfunction

endpackage

// ----- design/glyph_rom_address_calc.sv -----
// Top level of the glyph address calculator for a serial GB2312 / ASCII font ROM.
//
//   channel | dir | tdata                                   | tuser
//   s       | in  | char_code[15:0]                         | font_kind[2:0]
//   m       | out | glyph_addr, cols, rows, word_count, pad | addr_valid
//
// One word per cycle in each direction while the output is not stalled; each word
// passes through the decode, index and address register stages.
// Each stage holds its word while the one after it is full and stalled; the
// input keeps taking words while a finished word waits at the output until
// all three stages are full, then tready drops until the output moves.
// Reset clears the stage valid bits only.
module glyph_rom_address_calc (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,   // [15:0] char_code
    input  logic [2:0]  i_s_tuser,   // [2:0] font_kind
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [39:0] o_m_tdata,   // [17:0] glyph_addr, [22:18] glyph_cols,
                                     // [27:23] glyph_rows, [32:28] word_count, [39:33] zero
    output logic        o_m_tuser    // [0] addr_valid
);

    logic                  dec_valid;
    logic                  dec_ready;
    gra_pkg::t_dec_word    dec_data;
    logic                  idx_valid;
    logic                  idx_ready;
    gra_pkg::t_idx_word    idx_data;
    gra_pkg::t_out_word    out_data;

    gra_decode u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .o_ready (o_s_tready),
        .i_kind  (gra_pkg::t_font_kind'(i_s_tuser)),
        .i_code  (i_s_tdata),
        .o_valid (dec_valid),
        .i_ready (dec_ready),
        .o_data  (dec_data)
    );

    gra_index u_index (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (dec_valid),
        .o_ready (dec_ready),
        .i_data  (dec_data),
        .o_valid (idx_valid),
        .i_ready (idx_ready),
        .o_data  (idx_data)
    );

    gra_addr u_addr (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (idx_valid),
        .o_ready (idx_ready),
        .i_data  (idx_data),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_data  (out_data)
    );

    assign o_m_tdata = {7'd0, out_data.words, out_data.rows, out_data.cols, out_data.addr};
    assign o_m_tuser = out_data.ok;

endmodule

// ----- design/gra_decode.sv -----
// Stage 1: range checks and row/column offsets of the character code.
`include "glyph_rom_address_calc_macros.svh"

module gra_decode (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  gra_pkg::t_font_kind   i_kind,
    input  logic [15:0]           i_code,
    output logic                  o_valid,
    input  logic                  i_ready,
    output gra_pkg::t_dec_word    o_data
);

    logic                  r_valid;
    gra_pkg::t_dec_word    r_data;
    gra_pkg::t_dec_word    n_data;
    logic [7:0]            hi;
    logic [7:0]            lo;

    assign hi = i_code[15:8];
    assign lo = i_code[7:0];

    always_comb begin
        n_data         = '0;
        n_data.kind    = i_kind;
        n_data.col_off = gra_pkg::OFS_W'(lo - gra_pkg::HZ_LO_MIN);
        unique case (i_kind)
            gra_pkg::FONT_HANZI: begin
                priority if (lo < gra_pkg::HZ_LO_MIN) begin
                    n_data.ok = 1'b0;
                end else if (hi == gra_pkg::HZ_ROW_A9) begin
                    n_data.ok      = 1'b1;
                    n_data.idx_add = gra_pkg::HZ_A9_OFS;
                end else if (hi >= gra_pkg::HZ_ROW1_LO && hi <= gra_pkg::HZ_ROW1_HI) begin
                    n_data.ok      = 1'b1;
                    n_data.row_off = gra_pkg::OFS_W'(hi - gra_pkg::HZ_ROW1_LO);
                end else if (hi >= gra_pkg::HZ_ROW2_LO && hi <= gra_pkg::HZ_ROW2_HI) begin
                    n_data.ok      = 1'b1;
                    n_data.row_off = gra_pkg::OFS_W'(hi - gra_pkg::HZ_ROW2_LO);
                    n_data.idx_add = gra_pkg::HZ_ROW2_OFS;
                end else begin
                    n_data.ok = 1'b0;
                end
            end
            gra_pkg::FONT_GB8X16: begin
                priority if (hi == gra_pkg::GB_ROW_A && lo >= gra_pkg::HZ_LO_MIN
                             && lo <= gra_pkg::GB_LO_MAX_A) begin
                    n_data.ok = 1'b1;
                end else if (hi == gra_pkg::GB_ROW_B && lo >= gra_pkg::HZ_LO_MIN
                             && lo <= gra_pkg::GB_LO_MAX_B) begin
                    n_data.ok      = 1'b1;
                    n_data.idx_add = gra_pkg::GB_B_OFS;
                end else begin
                    n_data.ok = 1'b0;
                end
            end
            default: begin
                n_data.ok      = (i_code >= gra_pkg::ASC_MIN) && (i_code <= gra_pkg::ASC_MAX);
                n_data.col_off = i_code[gra_pkg::OFS_W-1:0] - gra_pkg::ASC_MIN_OFS;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    `GRA_ASSERT_IMPLY(a_row_in_range, i_clk, i_rst_n,
        r_valid && r_data.ok, r_data.row_off <= gra_pkg::OFS_W'(71))
    `GRA_ASSERT_NEXT(a_dec_hold, i_clk, i_rst_n,
        r_valid && !i_ready, r_valid && $stable(r_data))

endmodule

// ----- design/gra_index.sv -----
// Stage 2: glyph index from row offset times row length plus column and zone offsets.
`include "glyph_rom_address_calc_macros.svh"

module gra_index (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  gra_pkg::t_dec_word    i_data,
    output logic                  o_valid,
    input  logic                  i_ready,
    output gra_pkg::t_idx_word    o_data
);

    logic                  r_valid;
    gra_pkg::t_idx_word    r_data;
    gra_pkg::t_idx_word    n_data;
    logic [gra_pkg::IDX_W-1:0] row_base;

    assign row_base = gra_pkg::IDX_W'(i_data.row_off) * gra_pkg::HZ_ROW_LEN;

    always_comb begin
        n_data.kind = i_data.kind;
        n_data.ok   = i_data.ok;
        n_data.idx  = row_base + gra_pkg::IDX_W'(i_data.col_off)
                    + gra_pkg::IDX_W'(i_data.idx_add);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    `GRA_ASSERT_IMPLY(a_idx_in_range, i_clk, i_rst_n,
        r_valid && r_data.ok, r_data.idx <= gra_pkg::HZ_IDX_MAX)

endmodule

// ----- design/gra_addr.sv -----
// Stage 3: byte address from base plus index times stride, size table lookup.
`include "glyph_rom_address_calc_macros.svh"

module gra_addr (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  gra_pkg::t_idx_word    i_data,
    output logic                  o_valid,
    input  logic                  i_ready,
    output gra_pkg::t_out_word    o_data
);

    localparam int SUM_W = gra_pkg::ADDR_W + 2;

    logic                  r_valid;
    gra_pkg::t_out_word    r_data;
    gra_pkg::t_out_word    n_data;
    logic [SUM_W-1:0]      offset;
    logic [SUM_W-1:0]      sum;

    assign offset = SUM_W'(i_data.idx) * SUM_W'(gra_pkg::font_stride(i_data.kind));
    assign sum    = SUM_W'(gra_pkg::font_base(i_data.kind)) + offset;

    always_comb begin
        n_data.ok    = i_data.ok;
        // drop the address of a code outside the font's ranges
        n_data.addr  = i_data.ok ? sum[gra_pkg::ADDR_W-1:0] : '0;
        n_data.cols  = gra_pkg::font_cols(i_data.kind);
        n_data.rows  = gra_pkg::font_rows(i_data.kind);
        n_data.words = gra_pkg::font_words(i_data.kind);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    `GRA_ASSERT_IMPLY(a_invalid_addr_zero, i_clk, i_rst_n,
        r_valid && !r_data.ok, r_data.addr == '0)

endmodule
